// File: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the seven-bit i2c master transfer core.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  localparam logic [15:0] STEP_TICKS_RST = 16'd5;

  // actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic        sda_in;
    logic [6:0]  slave_addr;
    logic [15:0] write_count;
    logic [15:0] read_count;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        need_data;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        read_last;
    logic        done_res;
    logic [1:0]  status;
  } result_t;

endpackage

// File: hdl/i2cm_in_stage.sv
// ----------------------------------------------------------------------------
// i2cm_in_stage
// Input register: takes one word from the input channel and unpacks it.
// ----------------------------------------------------------------------------
module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,
  input  logic [InUserW-1:0] in_tuser,
  input  logic               advance,
  output logic               item_valid,
  output item_t              item
);

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action      <= in_tuser[1:0];
      item_r.sda_in      <= in_tdata[0];
      item_r.slave_addr  <= in_tdata[7:1];
      item_r.write_count <= in_tdata[23:8];
      item_r.read_count  <= in_tdata[39:24];
      item_r.write_data  <= in_tdata[47:40];
    end
  end

endmodule

// File: hdl/i2cm_fsm.sv
// ----------------------------------------------------------------------------
// i2cm_fsm
// Bus sequencer: holds the transfer state and works out the line levels,
// received bytes and completion for one word.
// ----------------------------------------------------------------------------
module i2cm_fsm
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        advance,
  input  item_t       item,
  output result_t     result
);

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_START = 9'b000000010,
    PH_ADDR  = 9'b000000100,
    PH_DATA  = 9'b000001000,
    PH_WAIT  = 9'b000010000,
    PH_RPRE  = 9'b000100000,
    PH_RBIT  = 9'b001000000,
    PH_RACK  = 9'b010000000,
    PH_STOP  = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  step_index;
    logic [3:0]  bit_count;
    logic [15:0] tick_count;
    logic [7:0]  shift_reg;
    logic [7:0]  hold_byte;
    logic        hold_valid;
    logic [6:0]  target_address;
    logic [15:0] writes_left;
    logic [15:0] reads_left;
    logic [1:0]  result_status;
    logic        scl_level;
    logic        sda_level;
  } state_t;

  localparam state_t STATE_RST = '{
    phase: PH_IDLE, step_index: 3'd0, bit_count: 4'd0, tick_count: 16'd0,
    shift_reg: 8'd0, hold_byte: 8'd0, hold_valid: 1'b0, target_address: 7'd0,
    writes_left: 16'd0, reads_left: 16'd0, result_status: ST_OK,
    scl_level: 1'b1, sda_level: 1'b1
  };

  state_t      st_r, st_nxt;
  logic [15:0] step_ticks_r;
  logic [15:0] limit;
  logic [16:0] tick_inc;

  function automatic state_t apply_step(input state_t s_in);
    state_t s;
    s = s_in;
    case (s.phase)
      PH_START: begin
        if (s.step_index == 3'd0) s.scl_level = 1'b1;
        else if (s.step_index == 3'd1) s.sda_level = 1'b1;
        else s.sda_level = 1'b0;
      end
      PH_ADDR, PH_DATA: begin
        if (s.bit_count < 4'd8) begin
          if (s.step_index == 3'd0) s.scl_level = 1'b0;
          else if (s.step_index == 3'd1)
            s.sda_level = s.shift_reg[3'd7 - s.bit_count[2:0]];
          else s.scl_level = 1'b1;
        end else begin
          if (s.step_index == 3'd0) s.scl_level = 1'b0;
          else if (s.step_index == 3'd1) s.sda_level = 1'b1;
          else if (s.step_index == 3'd2) s.scl_level = 1'b1;
          else s.scl_level = 1'b0;
        end
      end
      PH_RPRE: begin
        if (s.step_index == 3'd0) s.scl_level = 1'b0;
        else s.sda_level = 1'b1;
      end
      PH_RBIT: begin
        s.scl_level = (s.step_index != 3'd0);
      end
      PH_RACK: begin
        if (s.step_index == 3'd0) s.scl_level = 1'b0;
        else if (s.step_index == 3'd1) s.sda_level = (s.reads_left == 16'd1);
        else if (s.step_index == 3'd2) s.scl_level = 1'b1;
        else if (s.step_index == 3'd3) s.scl_level = 1'b0;
        else s.sda_level = 1'b1;
      end
      PH_STOP: begin
        if (s.step_index == 3'd0) s.scl_level = 1'b0;
        else if (s.step_index == 3'd1) s.sda_level = 1'b0;
        else if (s.step_index == 3'd2) s.scl_level = 1'b1;
        else s.sda_level = 1'b1;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic state_t enter(input state_t s_in, input phase_t p);
    state_t s;
    s = s_in;
    s.phase      = p;
    s.step_index = 3'd0;
    s.bit_count  = 4'd0;
    s.tick_count = 16'd0;
    return apply_step(s);
  endfunction

  function automatic state_t next_write(input state_t s_in);
    state_t s;
    s = s_in;
    if (s.writes_left != 16'd0) begin
      if (s.hold_valid) begin
        s.shift_reg   = s.hold_byte;
        s.hold_valid  = 1'b0;
        s.writes_left = s.writes_left - 16'd1;
        s = enter(s, PH_DATA);
      end else begin
        s.phase      = PH_WAIT;
        s.step_index = 3'd0;
        s.bit_count  = 4'd0;
        s.tick_count = 16'd0;
      end
    end else if (s.reads_left != 16'd0) begin
      s.shift_reg = {s.target_address, 1'b1};
      s = enter(s, PH_START);
    end else begin
      s = enter(s, PH_STOP);
    end
    return s;
  endfunction

  assign limit    = (step_ticks_r == 16'd0) ? 16'd1 : step_ticks_r;
  assign tick_inc = {1'b0, st_r.tick_count} + 17'd1;

  always_comb begin
    st_nxt = st_r;
    result = '0;
    case (item.action)
      ACT_TICK: begin
        if (st_r.phase != PH_IDLE && st_r.phase != PH_WAIT) begin
          if (tick_inc >= {1'b0, limit}) begin
            st_nxt.tick_count = 16'd0;
            case (st_r.phase)
              PH_START: begin
                if (st_nxt.step_index < 3'd2) begin
                  st_nxt.step_index = st_nxt.step_index + 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else begin
                  st_nxt = enter(st_nxt, PH_ADDR);
                end
              end
              PH_ADDR, PH_DATA: begin
                if (st_nxt.bit_count < 4'd8) begin
                  if (st_nxt.step_index < 3'd2) begin
                    st_nxt.step_index = st_nxt.step_index + 3'd1;
                  end else begin
                    st_nxt.step_index = 3'd0;
                    st_nxt.bit_count  = st_nxt.bit_count + 4'd1;
                  end
                  st_nxt = apply_step(st_nxt);
                end else if (st_nxt.step_index < 3'd3) begin
                  if (st_nxt.step_index == 3'd2 && item.sda_in)
                    st_nxt.result_status = (st_r.phase == PH_ADDR) ? ST_ADDR_NACK
                                                                   : ST_DATA_NACK;
                  st_nxt.step_index = st_nxt.step_index + 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else if (st_nxt.result_status != ST_OK) begin
                  st_nxt = enter(st_nxt, PH_STOP);
                end else if (st_r.phase == PH_ADDR && st_nxt.shift_reg[0]) begin
                  st_nxt = enter(st_nxt, PH_RPRE);
                end else begin
                  st_nxt = next_write(st_nxt);
                end
              end
              PH_RPRE: begin
                if (st_nxt.step_index == 3'd0) begin
                  st_nxt.step_index = 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else begin
                  st_nxt = enter(st_nxt, PH_RBIT);
                  st_nxt.shift_reg = 8'd0;
                end
              end
              PH_RBIT: begin
                if (st_nxt.step_index == 3'd0) begin
                  st_nxt.step_index = 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else begin
                  st_nxt.shift_reg = {st_nxt.shift_reg[6:0], item.sda_in};
                  st_nxt.bit_count = st_nxt.bit_count + 4'd1;
                  if (st_nxt.bit_count >= 4'd8) begin
                    result.read_valid = 1'b1;
                    result.read_data  = st_nxt.shift_reg;
                    result.read_last  = (st_nxt.reads_left == 16'd1);
                    st_nxt = enter(st_nxt, PH_RACK);
                  end else begin
                    st_nxt.step_index = 3'd0;
                    st_nxt = apply_step(st_nxt);
                  end
                end
              end
              PH_RACK: begin
                if (st_nxt.step_index < 3'd4) begin
                  st_nxt.step_index = st_nxt.step_index + 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else begin
                  st_nxt.reads_left = st_nxt.reads_left - 16'd1;
                  if (st_nxt.reads_left != 16'd0) st_nxt = enter(st_nxt, PH_RPRE);
                  else st_nxt = enter(st_nxt, PH_STOP);
                end
              end
              PH_STOP: begin
                if (st_nxt.step_index < 3'd3) begin
                  st_nxt.step_index = st_nxt.step_index + 3'd1;
                  st_nxt = apply_step(st_nxt);
                end else begin
                  result.done_res   = 1'b1;
                  result.status     = st_nxt.result_status;
                  st_nxt.hold_valid = 1'b0;
                  st_nxt.phase      = PH_IDLE;
                  st_nxt.step_index = 3'd0;
                  st_nxt.bit_count  = 4'd0;
                  st_nxt.tick_count = 16'd0;
                end
              end
              default: ;
            endcase
          end else begin
            st_nxt.tick_count = tick_inc[15:0];
          end
        end
      end
      ACT_BEGIN: begin
        if (st_r.phase == PH_IDLE) begin
          if (item.write_count == 16'd0 && item.read_count == 16'd0) begin
            result.done_res = 1'b1;
            result.status   = ST_INVALID;
          end else begin
            st_nxt.target_address = item.slave_addr;
            st_nxt.writes_left    = item.write_count;
            st_nxt.reads_left     = item.read_count;
            st_nxt.result_status  = ST_OK;
            st_nxt.scl_level      = 1'b1;
            st_nxt.sda_level      = 1'b1;
            st_nxt.shift_reg      = {item.slave_addr, (item.write_count == 16'd0)};
            st_nxt = enter(st_nxt, PH_START);
          end
        end
      end
      ACT_LOAD: begin
        if (!st_r.hold_valid) begin
          st_nxt.hold_byte  = item.write_data;
          st_nxt.hold_valid = 1'b1;
          if (st_r.phase == PH_WAIT) st_nxt = next_write(st_nxt);
        end
      end
      default: ;
    endcase
    result.scl_out   = st_nxt.scl_level;
    result.sda_out   = st_nxt.sda_level;
    result.busy_res  = (st_nxt.phase != PH_IDLE);
    result.need_data = (st_nxt.phase != PH_IDLE) && (st_nxt.writes_left != 16'd0)
                       && !st_nxt.hold_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= STEP_TICKS_RST;
    end else if (cfg_we) begin
      step_ticks_r <= cfg_wdata;
    end
  end

endmodule

// File: hdl/i2c_master_transfer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_core
// Seven-bit i2c master driving open-drain scl and sda levels from tick words.
// ----------------------------------------------------------------------------
// in_* channel: one word per tick, begin or load command; in_tuser holds the
//   action, in_tdata the line sample and command fields.
// out_* channel: exactly one result word per input word, in order, giving the
//   line drive levels, busy, need-data, a received byte and completion status.
//   out_tlast marks the last byte of a read.
// cfg_we / cfg_wdata: sets the ticks per line step; write only while idle.
// Path: a word accepted into the input register is processed combinationally
//   and its result is registered in the result register and offered from then on.
// Throughput: one word per cycle while the output is not stalled, set by the
//   combinational state update between the input register and the result register.
// Reset: both lines released, sequencer idle, holding register empty, step
//   length 5 ticks.
// Stall: while out_tready is low the result register holds; the input register
//   takes one more word, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_master_transfer_core
  import i2cm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // sda_in, slave_addr, write_count, read_count, write_data
  input  logic [InDataW-1:0]  in_tdata,
  // action
  input  logic [InUserW-1:0]  in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // scl_out, sda_out, busy_res, need_data, read_data, read_valid, done_res, status
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    advance;
  logic    out_valid_r;
  result_t out_data_r;

  assign advance = item_valid && (!out_valid_r || out_tready);

  i2cm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cm_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r.read_last;
  assign out_tdata  = {out_data_r.status, out_data_r.done_res, out_data_r.read_valid,
                       out_data_r.read_data, out_data_r.need_data, out_data_r.busy_res,
                       out_data_r.sda_out, out_data_r.scl_out};

endmodule

// File: test/transfer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_checker
// Watches the configuration port and both word channels of the i2c master
// transfer core. Each accepted input word is run through a cycle-free copy of
// the line sequencer, and the predicted result word is queued. Every result
// word taken from the core is compared field by field with the oldest queued
// prediction. Failures and the number of predictions still waiting are passed
// up to the testbench top.
// ----------------------------------------------------------------------------
module transfer_checker
  import i2cm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [InUserW-1:0]  in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tlast,
  output int                  fail_count,
  output int                  pending
);

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_ADDR, SEQ_DATA, SEQ_WAIT,
    SEQ_RPRE, SEQ_RBIT, SEQ_RACK, SEQ_STOP
  } seq_phase_t;

  seq_phase_t  seq;
  logic [3:0]  step_no;
  logic [3:0]  bits_done;
  logic [15:0] tick_no;
  logic [7:0]  shreg;
  logic [7:0]  held_byte;
  logic        held;
  logic [6:0]  target;
  logic [15:0] writes_rem;
  logic [15:0] reads_rem;
  logic [1:0]  outcome;
  logic        scl_q;
  logic        sda_q;
  logic [15:0] step_len;

  logic        got_byte;
  logic [7:0]  byte_val;
  logic        byte_last;
  logic        got_done;
  logic [1:0]  done_code;

  result_t expected_q[$];
  int      errors_seen = 0;
  int      queued = 0;

  assign fail_count = errors_seen;
  assign pending    = queued;

  function automatic void clear_state();
    seq        = SEQ_IDLE;
    step_no    = '0;
    bits_done  = '0;
    tick_no    = '0;
    shreg      = '0;
    held_byte  = '0;
    held       = 1'b0;
    target     = '0;
    writes_rem = '0;
    reads_rem  = '0;
    outcome    = ST_OK;
    scl_q      = 1'b1;
    sda_q      = 1'b1;
    step_len   = STEP_TICKS_RST;
  endfunction

  // line levels for the current step
  function automatic void drive_step();
    case (seq)
      SEQ_START: begin
        if (step_no == 0) scl_q = 1'b1;
        else if (step_no == 1) sda_q = 1'b1;
        else sda_q = 1'b0;
      end
      SEQ_ADDR, SEQ_DATA: begin
        if (bits_done < 8) begin
          if (step_no == 0) scl_q = 1'b0;
          else if (step_no == 1) sda_q = shreg[7 - bits_done];
          else scl_q = 1'b1;
        end else begin
          if (step_no == 0) scl_q = 1'b0;
          else if (step_no == 1) sda_q = 1'b1;
          else if (step_no == 2) scl_q = 1'b1;
          else scl_q = 1'b0;
        end
      end
      SEQ_RPRE: begin
        if (step_no == 0) scl_q = 1'b0;
        else sda_q = 1'b1;
      end
      SEQ_RBIT: scl_q = (step_no != 0);
      SEQ_RACK: begin
        if (step_no == 0) scl_q = 1'b0;
        else if (step_no == 1) sda_q = (reads_rem == 16'd1);
        else if (step_no == 2) scl_q = 1'b1;
        else if (step_no == 3) scl_q = 1'b0;
        else sda_q = 1'b1;
      end
      SEQ_STOP: begin
        if (step_no == 0) scl_q = 1'b0;
        else if (step_no == 1) sda_q = 1'b0;
        else if (step_no == 2) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void go(seq_phase_t p);
    seq       = p;
    step_no   = '0;
    bits_done = '0;
    tick_no   = '0;
    drive_step();
  endfunction

  function automatic void fetch_next();
    if (writes_rem != 0) begin
      if (held) begin
        shreg      = held_byte;
        held       = 1'b0;
        writes_rem = writes_rem - 16'd1;
        go(SEQ_DATA);
      end else begin
        seq       = SEQ_WAIT;
        step_no   = '0;
        bits_done = '0;
        tick_no   = '0;
      end
    end else if (reads_rem != 0) begin
      shreg = {target, 1'b1};
      go(SEQ_START);
    end else begin
      go(SEQ_STOP);
    end
  endfunction

  // s is the sda level seen on the last tick of the step
  function automatic void end_of_step(logic s);
    case (seq)
      SEQ_START: begin
        if (step_no < 2) begin
          step_no++;
          drive_step();
        end else begin
          go(SEQ_ADDR);
        end
      end
      SEQ_ADDR, SEQ_DATA: begin
        if (bits_done < 8) begin
          if (step_no < 2) begin
            step_no++;
          end else begin
            step_no = '0;
            bits_done++;
          end
          drive_step();
        end else if (step_no < 3) begin
          if (step_no == 2 && s) outcome = (seq == SEQ_ADDR) ? ST_ADDR_NACK : ST_DATA_NACK;
          step_no++;
          drive_step();
        end else if (outcome != ST_OK) begin
          go(SEQ_STOP);
        end else if (seq == SEQ_ADDR && shreg[0]) begin
          go(SEQ_RPRE);
        end else begin
          fetch_next();
        end
      end
      SEQ_RPRE: begin
        if (step_no == 0) begin
          step_no = 4'd1;
          drive_step();
        end else begin
          go(SEQ_RBIT);
          shreg = '0;
        end
      end
      SEQ_RBIT: begin
        if (step_no == 0) begin
          step_no = 4'd1;
          drive_step();
        end else begin
          shreg = {shreg[6:0], s};
          bits_done++;
          if (bits_done >= 8) begin
            got_byte  = 1'b1;
            byte_val  = shreg;
            byte_last = (reads_rem == 16'd1);
            go(SEQ_RACK);
          end else begin
            step_no = '0;
            drive_step();
          end
        end
      end
      SEQ_RACK: begin
        if (step_no < 4) begin
          step_no++;
          drive_step();
        end else begin
          reads_rem = reads_rem - 16'd1;
          if (reads_rem != 0) go(SEQ_RPRE);
          else go(SEQ_STOP);
        end
      end
      SEQ_STOP: begin
        if (step_no < 3) begin
          step_no++;
          drive_step();
        end else begin
          got_done  = 1'b1;
          done_code = outcome;
          held      = 1'b0;
          seq       = SEQ_IDLE;
          step_no   = '0;
          bits_done = '0;
          tick_no   = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t predict_word(item_t w);
    result_t     r;
    logic [15:0] lim;
    logic        busy;
    got_byte  = 1'b0;
    byte_val  = '0;
    byte_last = 1'b0;
    got_done  = 1'b0;
    done_code = ST_OK;
    lim = (step_len == 0) ? 16'd1 : step_len;
    case (w.action)
      ACT_TICK: begin
        if (seq != SEQ_IDLE && seq != SEQ_WAIT) begin
          tick_no++;
          if (tick_no >= lim) begin
            tick_no = '0;
            end_of_step(w.sda_in);
          end
        end
      end
      ACT_BEGIN: begin
        if (seq == SEQ_IDLE) begin
          if (w.write_count == 0 && w.read_count == 0) begin
            got_done  = 1'b1;
            done_code = ST_INVALID;
          end else begin
            target     = w.slave_addr;
            writes_rem = w.write_count;
            reads_rem  = w.read_count;
            outcome    = ST_OK;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            shreg      = {w.slave_addr, (w.write_count == 16'd0)};
            go(SEQ_START);
          end
        end
      end
      ACT_LOAD: begin
        if (!held) begin
          held_byte = w.write_data;
          held      = 1'b1;
          if (seq == SEQ_WAIT) fetch_next();
        end
      end
      default: ;
    endcase
    busy = (seq != SEQ_IDLE);
    r.scl_out    = scl_q;
    r.sda_out    = sda_q;
    r.busy_res   = busy;
    r.need_data  = busy && writes_rem != 0 && !held;
    r.read_data  = byte_val;
    r.read_valid = got_byte;
    r.read_last  = byte_last;
    r.done_res   = got_done;
    r.status     = done_code;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors_seen++;
    end
  endfunction

  always @(posedge clk) begin
    item_t   w;
    result_t exp_r;
    result_t got_r;
    if (!rst_n) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (cfg_we) step_len = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got_r.scl_out    = out_tdata[0];
        got_r.sda_out    = out_tdata[1];
        got_r.busy_res   = out_tdata[2];
        got_r.need_data  = out_tdata[3];
        got_r.read_data  = out_tdata[11:4];
        got_r.read_valid = out_tdata[12];
        got_r.done_res   = out_tdata[13];
        got_r.status     = out_tdata[15:14];
        got_r.read_last  = out_tlast;
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting: %0h", out_tdata);
          errors_seen++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("scl_out", exp_r.scl_out, got_r.scl_out);
          check_field("sda_out", exp_r.sda_out, got_r.sda_out);
          check_field("busy_res", exp_r.busy_res, got_r.busy_res);
          check_field("need_data", exp_r.need_data, got_r.need_data);
          check_field("read_data", exp_r.read_data, got_r.read_data);
          check_field("read_valid", exp_r.read_valid, got_r.read_valid);
          check_field("read_last", exp_r.read_last, got_r.read_last);
          check_field("done_res", exp_r.done_res, got_r.done_res);
          check_field("status", exp_r.status, got_r.status);
        end
      end
      if (in_tvalid && in_tready) begin
        w.action      = in_tuser;
        w.sda_in      = in_tdata[0];
        w.slave_addr  = in_tdata[7:1];
        w.write_count = in_tdata[23:8];
        w.read_count  = in_tdata[39:24];
        w.write_data  = in_tdata[47:40];
        expected_q.push_back(predict_word(w));
      end
    end
    queued = expected_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the i2c master transfer core. A short directed
// opening covers idle commands, an empty request, a held byte, maximum counts
// and the main transfer shapes; random phases then run transfers with random
// addresses, counts, line samples and load rates over several step lengths
// and idling patterns. The transfer checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  localparam int         QuietLimit = 2000;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  typedef enum int {LINE_LOW, LINE_ACKISH, LINE_COIN, LINE_HIGH} line_mode_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [15:0]         cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [InUserW-1:0]  in_tuser   = ACT_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int n_recv    = 0;
  int real_ends = 0;
  int quiet     = 0;
  int fails;
  int pending;

  i2c_master_transfer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  transfer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) n_sent <= n_sent + 1;
      if (out_tvalid && out_tready) begin
        n_recv <= n_recv + 1;
        if (out_tdata[13] && out_tdata[15:14] != ST_INVALID) real_ends <= real_ends + 1;
      end
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic line_level(line_mode_t m);
    case (m)
      LINE_LOW:    return 1'b0;
      LINE_ACKISH: return ($urandom_range(7) == 0);
      LINE_COIN:   return 1'($urandom_range(1));
      default:     return 1'b1;
    endcase
  endfunction

  // sda_in, slave_addr, write_count, read_count, write_data from the lowest bit up
  function automatic logic [InDataW-1:0] noise_fields(logic sda);
    return {8'($urandom), 16'($urandom), 16'($urandom), 7'($urandom), sda};
  endfunction

  task automatic send_word(logic [1:0] act, logic [InDataW-1:0] fields);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= fields;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_command(logic [1:0] act, logic sda, logic [6:0] addr,
                              logic [15:0] wc, logic [15:0] rc, logic [7:0] data);
    send_word(act, {data, rc, wc, addr, sda});
  endtask

  task automatic filler_word(line_mode_t m, int load_pct);
    int unsigned        pick;
    logic [InDataW-1:0] f;
    pick = $urandom_range(99);
    f    = noise_fields(line_level(m));
    if (pick < load_pct) begin
      send_word(ACT_LOAD, f);
    end else if (pick < load_pct + 4) begin
      // empty request: dropped while busy, harmless once idle
      f[39:8] = '0;
      send_word(ACT_BEGIN, f);
    end else if (pick < load_pct + 7) begin
      send_word(ACT_NONE, f);
    end else begin
      send_word(ACT_TICK, f);
    end
  endtask

  task automatic idle_noise();
    int unsigned        pick;
    logic [InDataW-1:0] f;
    pick = $urandom_range(3);
    f    = noise_fields(1'($urandom_range(1)));
    if (pick == 0) begin
      f[39:8] = '0;
      send_word(ACT_BEGIN, f);
    end else if (pick == 1) begin
      send_word(ACT_LOAD, f);
    end else if (pick == 2) begin
      send_word(ACT_NONE, f);
    end else begin
      send_word(ACT_TICK, f);
    end
  endtask

  task automatic run_transfer(logic [6:0] addr, logic [15:0] wc, logic [15:0] rc,
                              line_mode_t m, int load_pct);
    int ends_goal;
    ends_goal = real_ends + 1;
    send_command(ACT_BEGIN, line_level(m), addr, wc, rc, 8'($urandom));
    if (wc == 0 && rc == 0) return;
    while (real_ends < ends_goal) filler_word(m, load_pct);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_recv != n_sent);
  endtask

  task automatic write_step_len(logic [15:0] v);
    drain();
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_transfer();
    int unsigned pick;
    logic [6:0]  addr;
    int          load_pct;
    pick     = $urandom_range(99);
    addr     = 7'($urandom);
    load_pct = ($urandom_range(2) == 0) ? 2 : 20;
    if ($urandom_range(4) == 0) send_command(ACT_LOAD, 1'b0, addr, '0, '0, 8'($urandom));
    if (pick < 78) begin
      run_transfer(addr, 16'($urandom_range(3)), 16'($urandom_range(3)),
                   ($urandom_range(3) == 0) ? LINE_COIN : LINE_ACKISH, load_pct);
    end else if (pick < 90) begin
      run_transfer(addr, 16'($urandom), 16'($urandom_range(3)), LINE_COIN, load_pct);
    end else begin
      // long reads are cut short by a refused address
      run_transfer(addr, 16'($urandom), 16'($urandom), LINE_HIGH, load_pct);
    end
  endtask

  task automatic random_phase(logic [15:0] len, int sender_idle, int recv_stall, int words);
    int stop_at;
    write_step_len(len);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    stop_at   = n_sent + words;
    while (n_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        idle_noise();
      end else begin
        if ($urandom_range(3) == 0) drain();
        random_transfer();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(ACT_TICK, 1'b1, 7'h00, 16'h0000, 16'h0000, 8'h00);
    send_command(ACT_NONE, 1'b0, 7'h7F, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_command(ACT_BEGIN, 1'b0, 7'h7F, 16'h0000, 16'h0000, 8'h00);
    send_command(ACT_LOAD, 1'b0, 7'h00, 16'h0000, 16'h0000, 8'hFF);
    send_command(ACT_LOAD, 1'b1, 7'h00, 16'h0000, 16'h0000, 8'h00);
    run_transfer(7'h7F, 16'hFFFF, 16'hFFFF, LINE_HIGH, 20);

    write_step_len(16'd1);
    run_transfer(7'h00, 16'd1, 16'd1, LINE_LOW, 20);
    run_transfer(7'h55, 16'd0, 16'd2, LINE_ACKISH, 20);
    run_transfer(7'h2A, 16'd3, 16'd0, LINE_ACKISH, 2);
    run_transfer(7'h01, 16'd2, 16'd1, LINE_COIN, 20);

    write_step_len(16'hFFFF);
    repeat (12) idle_noise();

    random_phase(16'd1, 0, 0, 220);
    random_phase(16'd2, 49, 0, 220);
    random_phase(16'd0, 0, 49, 220);
    random_phase(16'd1, 18, 18, 220);

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: i2c_master_transfer_core.f
hdl/i2cm_pkg.sv
hdl/i2cm_in_stage.sv
hdl/i2cm_fsm.sv
hdl/i2c_master_transfer_core.sv
test/transfer_checker.sv
test/testbench.sv
